// File: rtl/csv_field_tokenizer_core_macros.svh
// Assertion macros used by the CSV tokenizer core.
`ifndef CSV_FIELD_TOKENIZER_CORE_MACROS_SVH
`define CSV_FIELD_TOKENIZER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CSVT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CSVT_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CSVT_ASSERT(lbl, clk, rstn, prop, msg)
`define CSVT_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: rtl/csvt_pkg.sv
// Types and constants shared by the CSV tokenizer modules.
`timescale 1ns / 1ps
`default_nettype none
package csvt_pkg;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam int unsigned LINE_OUT_BITS = 24;

    localparam logic [1:0] CFG_DELIMITER   = 2'd0;
    localparam logic [1:0] CFG_QUOTE       = 2'd1;
    localparam logic [1:0] CFG_HEADER_MODE = 2'd2;

    typedef enum logic [3:0] {
        MODE_START  = 4'b0001,
        MODE_PLAIN  = 4'b0010,
        MODE_QUOTED = 4'b0100,
        MODE_QCLOSE = 4'b1000
    } mode_t;

    typedef enum logic [2:0] {
        EV_BYTE      = 3'd0,
        EV_FIELD     = 3'd1,
        EV_FIELD_ROW = 3'd2,
        EV_ROW       = 3'd3,
        EV_UNTERM    = 3'd4
    } event_t;

    typedef struct packed {
        mode_t mode;
        logic  row_has_fields;
        logic  header_pending;
    } parse_state_t;

    typedef struct packed {
        parse_state_t next;
        logic [1:0]   count;
        event_t       kind0;
        logic [7:0]   byte0;
        event_t       kind1;
        logic [7:0]   byte1;
        logic         line_inc;
        logic         line_clear;
    } parse_step_t;

    typedef struct packed {
        event_t                   kind;
        logic [7:0]               fbyte;
        logic [LINE_OUT_BITS-1:0] line;
        logic                     hdr;
        logic                     last;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/csvt_parse.sv
// Per-byte parser step: next parse state and the events caused by one item.
`timescale 1ns / 1ps
`default_nettype none
module csvt_parse (
    input  var csvt_pkg::parse_state_t cur,
    input  wire logic [7:0]            text_byte,
    input  wire logic                  end_of_text,
    input  wire logic [7:0]            delimiter_byte,
    input  wire logic [7:0]            quote_byte,
    output csvt_pkg::parse_step_t      step
);

    logic [7:0] d;
    logic [7:0] q;
    logic       eot;
    logic       eol;
    logic       is_lf;

    assign d     = (delimiter_byte == csvt_pkg::CH_NUL) ? csvt_pkg::CH_COMMA : delimiter_byte;
    assign q     = (quote_byte == csvt_pkg::CH_NUL) ? csvt_pkg::CH_DQUOTE : quote_byte;
    assign eot   = end_of_text || (text_byte == csvt_pkg::CH_NUL);
    assign is_lf = (text_byte == csvt_pkg::CH_LF);
    assign eol   = is_lf || (text_byte == csvt_pkg::CH_CR);

    always_comb
    begin
        step            = '0;
        step.next       = cur;
        step.kind0      = csvt_pkg::EV_BYTE;
        step.kind1      = csvt_pkg::EV_BYTE;
        step.line_inc   = 1'b0;
        step.line_clear = 1'b0;
        if (eot)
        begin
            case (cur.mode)
                csvt_pkg::MODE_PLAIN, csvt_pkg::MODE_QCLOSE:
                begin
                    step.count = 2'd1;
                    step.kind0 = csvt_pkg::EV_FIELD_ROW;
                end
                csvt_pkg::MODE_QUOTED:
                begin
                    // The partial field is reported, then the row is closed if it had fields.
                    step.count = cur.row_has_fields ? 2'd2 : 2'd1;
                    step.kind0 = csvt_pkg::EV_UNTERM;
                    step.kind1 = csvt_pkg::EV_ROW;
                end
                default:
                begin
                    step.count = cur.row_has_fields ? 2'd1 : 2'd0;
                    step.kind0 = csvt_pkg::EV_ROW;
                end
            endcase
            step.next.mode           = csvt_pkg::MODE_START;
            step.next.row_has_fields = 1'b0;
            step.next.header_pending = 1'b1;
            step.line_clear          = 1'b1;
        end
        else
        begin
            case (cur.mode)
                csvt_pkg::MODE_PLAIN:
                begin
                    if (text_byte == d)
                    begin
                        step.count               = 2'd1;
                        step.kind0               = csvt_pkg::EV_FIELD;
                        step.next.row_has_fields = 1'b1;
                        step.next.mode           = csvt_pkg::MODE_START;
                    end
                    else if (eol)
                    begin
                        step.count               = 2'd1;
                        step.kind0               = csvt_pkg::EV_FIELD_ROW;
                        step.next.header_pending = 1'b0;
                        step.next.row_has_fields = 1'b0;
                        step.next.mode           = csvt_pkg::MODE_START;
                        step.line_inc            = is_lf;
                    end
                    else
                    begin
                        step.count = 2'd1;
                        step.byte0 = text_byte;
                    end
                end
                csvt_pkg::MODE_QUOTED:
                begin
                    if (text_byte == q)
                    begin
                        step.next.mode = csvt_pkg::MODE_QCLOSE;
                    end
                    else
                    begin
                        step.count    = 2'd1;
                        step.byte0    = text_byte;
                        step.line_inc = is_lf;
                    end
                end
                csvt_pkg::MODE_QCLOSE:
                begin
                    if (text_byte == q)
                    begin
                        // A doubled quote stands for one literal quote.
                        step.count     = 2'd1;
                        step.byte0     = q;
                        step.next.mode = csvt_pkg::MODE_QUOTED;
                    end
                    else if (text_byte == d)
                    begin
                        step.count               = 2'd1;
                        step.kind0               = csvt_pkg::EV_FIELD;
                        step.next.row_has_fields = 1'b1;
                        step.next.mode           = csvt_pkg::MODE_START;
                    end
                    else if (eol)
                    begin
                        step.count               = 2'd1;
                        step.kind0               = csvt_pkg::EV_FIELD_ROW;
                        step.next.header_pending = 1'b0;
                        step.next.row_has_fields = 1'b0;
                        step.next.mode           = csvt_pkg::MODE_START;
                        step.line_inc            = is_lf;
                    end
                    else
                    begin
                        // Text after a closing quote ends that field and opens a new one.
                        step.count               = 2'd2;
                        step.kind0               = csvt_pkg::EV_FIELD;
                        step.byte1               = text_byte;
                        step.next.row_has_fields = 1'b1;
                        step.next.mode           = csvt_pkg::MODE_PLAIN;
                    end
                end
                default:
                begin
                    if (eol)
                    begin
                        if (cur.row_has_fields)
                        begin
                            step.count               = 2'd1;
                            step.kind0               = csvt_pkg::EV_ROW;
                            step.next.header_pending = 1'b0;
                            step.next.row_has_fields = 1'b0;
                        end
                        step.next.mode = csvt_pkg::MODE_START;
                        step.line_inc  = is_lf;
                    end
                    else if (text_byte == q)
                    begin
                        step.next.mode = csvt_pkg::MODE_QUOTED;
                    end
                    else if (text_byte == d)
                    begin
                        step.count               = 2'd1;
                        step.kind0               = csvt_pkg::EV_FIELD;
                        step.next.row_has_fields = 1'b1;
                        step.next.mode           = csvt_pkg::MODE_START;
                    end
                    else
                    begin
                        step.count     = 2'd1;
                        step.byte0     = text_byte;
                        step.next.mode = csvt_pkg::MODE_PLAIN;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/csv_field_tokenizer_core.sv
// An accepted item is held in the input register; its results are registered in two slots.
// Throughput: one item per cycle while m_tready is high; an item with two results holds
// the single output port until both are taken, and the next item waits for that.
// Reset (rst_n low, asynchronous): parser at field start, line count one, header pending,
// registers back to comma, double quote and header mode off; no memory to clear.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_field_tokenizer_core_macros.svh"
module csv_field_tokenizer_core #(
    parameter int unsigned LINE_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] field_byte, [31:8] line_number
    output logic [3:0]       m_tuser,   // [2:0] event_kind, [3] is_header_row
    output logic             m_tlast,   // run_last
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    logic [7:0]                 delimiter_reg;
    logic [7:0]                 quote_reg;
    logic                       header_mode_reg;

    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_eot_reg;

    csvt_pkg::parse_state_t     state_reg;
    logic [LINE_BITS-1:0]       line_count_reg;
    logic [LINE_BITS-1:0]       line_count_next;

    csvt_pkg::result_t          slot0_reg;
    csvt_pkg::result_t          slot1_reg;
    logic [1:0]                 out_cnt_reg;

    csvt_pkg::parse_step_t      step;
    csvt_pkg::result_t          res0;
    csvt_pkg::result_t          res1;
    logic [31:0]                line_wide;
    logic                       out_fire;
    logic                       out_free;
    logic                       process;

    csvt_parse u_parse (
        .cur            (state_reg),
        .text_byte      (in_byte_reg),
        .end_of_text    (in_eot_reg),
        .delimiter_byte (delimiter_reg),
        .quote_byte     (quote_reg),
        .step           (step)
    );

    assign out_fire = m_tvalid && m_tready;
    // The output holds at most two results; an item moves on only once it is empty or emptying.
    assign out_free = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && out_fire);
    assign process  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign line_wide = 32'(line_count_reg);

    always_comb
    begin
        res0.kind  = step.kind0;
        res0.fbyte = step.byte0;
        res0.line  = line_wide[csvt_pkg::LINE_OUT_BITS-1:0];
        res0.hdr   = header_mode_reg && state_reg.header_pending;
        res0.last  = (step.count == 2'd1);
        res1.kind  = step.kind1;
        res1.fbyte = step.byte1;
        res1.line  = line_wide[csvt_pkg::LINE_OUT_BITS-1:0];
        res1.hdr   = header_mode_reg && state_reg.header_pending;
        res1.last  = 1'b1;
    end

    always_comb
    begin
        line_count_next = line_count_reg;
        if (step.line_clear)
        begin
            line_count_next = LINE_ONE;
        end
        else if (step.line_inc && (line_count_reg != LINE_MAX))
        begin
            line_count_next = line_count_reg + LINE_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg   <= csvt_pkg::CH_COMMA;
            quote_reg       <= csvt_pkg::CH_DQUOTE;
            header_mode_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                csvt_pkg::CFG_DELIMITER:   delimiter_reg   <= cfg_wdata;
                csvt_pkg::CFG_QUOTE:       quote_reg       <= cfg_wdata;
                csvt_pkg::CFG_HEADER_MODE: header_mode_reg <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_cnt_reg    <= 2'd0;
            state_reg      <= '{mode: csvt_pkg::MODE_START, row_has_fields: 1'b0,
                                header_pending: 1'b1};
            line_count_reg <= LINE_ONE;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (process)
            begin
                state_reg      <= step.next;
                line_count_reg <= line_count_next;
                out_cnt_reg    <= step.count;
            end
            else if (out_fire)
            begin
                out_cnt_reg <= out_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
        if (process && (step.count != 2'd0))
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (out_fire)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = {slot0_reg.line, slot0_reg.fbyte};
    assign m_tuser  = {slot0_reg.hdr, slot0_reg.kind};
    assign m_tlast  = slot0_reg.last;

    `CSVT_ASSERT(a_pair_first_not_last, clk, rst_n,
        (out_cnt_reg == 2'd2) |-> !slot0_reg.last, "first of two results marked last")
    `CSVT_ASSERT(a_single_is_last, clk, rst_n,
        (out_cnt_reg == 2'd1) |-> slot0_reg.last, "lone pending result not marked last")
    `CSVT_ASSERT(a_eot_restores, clk, rst_n,
        (process && step.line_clear) |=>
            (state_reg.mode == csvt_pkg::MODE_START) && (line_count_reg == LINE_ONE)
            && state_reg.header_pending && !state_reg.row_has_fields,
        "end of text did not restore the start state")
    `CSVT_ASSERT(a_line_monotonic, clk, rst_n,
        (process && !step.line_clear) |=> (line_count_reg >= $past(line_count_reg)),
        "line count went backwards")
    `CSVT_ASSERT_NEVER(a_header_no_rise, clk, rst_n,
        $rose(state_reg.header_pending) && !$past(process && step.line_clear),
        "header flag raised without end of text")

endmodule
`default_nettype wire
